/* hdl/bmt_pkg.sv */
package bmt_pkg;

  localparam int POS_W = 12;
  localparam int PROG_DEPTH_DEF = 4096;
  localparam int STACK_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    CMD_OPEN   = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_ORDER = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_RANGE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_OPEN    = 2'd1,
    KIND_CLOSE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WRITE2
  } state_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] partner;
  } entry_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [POS_W-1:0] data;
  } stk_ctl_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

/* hdl/bmt_stack.sv */
module bmt_stack import bmt_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  stk_ctl_t         ctl,
  output logic [POS_W-1:0] top,
  output logic             empty,
  output logic             full
);

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [POS_W-1:0] mem [STACK_DEPTH];
  logic [CW-1:0]    count;
  logic [CW-1:0]    top_ptr;

  assign top_ptr = count - CW'(1);
  assign empty   = (count == '0);
  assign full    = (count == CW'(STACK_DEPTH));

  // top word is read every cycle; after a push/pop it is stale until the next clock edge
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[count[SAW-1:0]] <= ctl.data;
    end
    top <= mem[top_ptr[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + CW'(1);
    end else if (ctl.pop) begin
      count <= count - CW'(1);
    end
  end

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop)) else $error("push and pop together");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !full) else $error("push on full stack");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !empty) else $error("pop on empty stack");

endmodule

/* hdl/bmt_table.sv */
module bmt_table import bmt_pkg::*; #(
  parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [POS_W-1:0] rd_addr,
  input  tbl_wr_t          wr,
  output entry_t           rd_data,
  output logic             clearing
);

  // positions are POS_W bits wide, so entries above that are never reachable
  localparam int TBL_DEPTH = (PROG_DEPTH < (1 << POS_W)) ? PROG_DEPTH : (1 << POS_W);
  localparam int TAW       = $clog2(TBL_DEPTH);

  entry_t         mem [TBL_DEPTH];
  logic [TAW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + TAW'(1);
      if (clr_addr == TAW'(TBL_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr.we) begin
      mem[wr.addr[TAW-1:0]] <= wr.data;
    end
    rd_data <= mem[rd_addr[TAW-1:0]];
  end

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> !clearing) else $error("table write during clear sweep");

endmodule

/* hdl/bmt_ctrl.sv */
module bmt_ctrl import bmt_pkg::*; #(
  parameter int PROG_DEPTH = PROG_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       cmd,
  input  logic [POS_W-1:0] position,
  input  logic             clearing,
  input  logic [POS_W-1:0] stk_top,
  input  logic             stk_empty,
  input  logic             stk_full,
  input  entry_t           rd_entry,
  output logic             busy,
  output stk_ctl_t         stk_ctl,
  output tbl_wr_t          tbl_wr,
  output logic [POS_W-1:0] tbl_rd_addr,
  output logic             done,
  output logic [2:0]       status,
  output logic [1:0]       kind,
  output logic [POS_W-1:0] partner
);

  state_t           state, state_next;
  logic [1:0]       cmd_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] left_q;
  logic             in_range;
  logic             res_valid;
  status_t          status_next;
  kind_t            kind_next;
  logic [POS_W-1:0] partner_next;

  assign busy        = clearing || (state != ST_IDLE);
  // table read is issued with the incoming word, data lands in ST_EXEC
  assign tbl_rd_addr = position;
  assign in_range    = ({{(32 - POS_W){1'b0}}, pos_q} < 32'(PROG_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
      pos_q <= position;
    end
    if (state == ST_EXEC) begin
      left_q <= stk_top;
    end
    status  <= status_next;
    kind    <= kind_next;
    partner <= partner_next;
  end

  always_comb begin
    state_next   = state;
    res_valid    = 1'b0;
    status_next  = STAT_OK;
    kind_next    = KIND_UNKNOWN;
    partner_next = '0;
    stk_ctl      = '0;
    stk_ctl.data = pos_q;
    tbl_wr       = '0;
    case (state)
      ST_IDLE: begin
        if (start && !busy) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_valid  = 1'b1;
        state_next = ST_IDLE;
        if (cmd_q == CMD_OPEN || cmd_q == CMD_CLOSE || cmd_q == CMD_LOOKUP) begin
          if (!in_range) begin
            status_next = STAT_RANGE;
          end else begin
            case (cmd_q)
              CMD_OPEN: begin
                if (stk_full) begin
                  status_next = STAT_FULL;
                end else begin
                  stk_ctl.push = 1'b1;
                end
              end
              CMD_CLOSE: begin
                if (stk_empty) begin
                  status_next = STAT_EMPTY;
                end else if (stk_top >= pos_q) begin
                  status_next = STAT_ORDER;
                end else begin
                  stk_ctl.pop          = 1'b1;
                  tbl_wr.we            = 1'b1;
                  tbl_wr.addr          = stk_top;
                  tbl_wr.data.kind     = KIND_OPEN;
                  tbl_wr.data.partner  = pos_q;
                  state_next           = ST_WRITE2;
                end
              end
              default: begin
                kind_next = rd_entry.kind;
                if (rd_entry.kind != KIND_UNKNOWN) begin
                  partner_next = rd_entry.partner;
                end
              end
            endcase
          end
        end
      end
      ST_WRITE2: begin
        // second half of a close: the close entry points back to its open
        tbl_wr.we           = 1'b1;
        tbl_wr.addr         = pos_q;
        tbl_wr.data.kind    = KIND_CLOSE;
        tbl_wr.data.partner = left_q;
        state_next          = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC)) else $error("strobe without execute");
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == ST_EXEC) else $error("accepted word not executed");
  a_write2_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE2 |-> $past(state == ST_EXEC && tbl_wr.we))
    else $error("second table write without first");

endmodule

/* hdl/bracket_match_table.sv */
// Result: an accepted word moves the controller to ST_EXEC, where the command executes, and done
// is registered from ST_EXEC. Each command returns to ST_IDLE before the next word is taken; a successful
// close also passes through ST_WRITE2, since both table entries go through the single table write port.
// Reset: synchronous; the stack count clears at once, then a sweep zeroes the table one
// entry per cycle (PROG_DEPTH entries, capped at 4096) while busy stays high.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module bracket_match_table import bmt_pkg::*; #(
  parameter int PROG_DEPTH  = PROG_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       cmd,
  input  logic [POS_W-1:0] position,
  output logic             busy,
  output logic             done,
  output logic [2:0]       status,
  output logic [1:0]       kind,
  output logic [POS_W-1:0] partner
);

  stk_ctl_t         stk_ctl;
  tbl_wr_t          tbl_wr;
  logic [POS_W-1:0] stk_top;
  logic             stk_empty;
  logic             stk_full;
  logic [POS_W-1:0] tbl_rd_addr;
  entry_t           rd_entry;
  logic             clearing;

  bmt_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .rst   (rst),
    .ctl   (stk_ctl),
    .top   (stk_top),
    .empty (stk_empty),
    .full  (stk_full)
  );

  bmt_table #(.PROG_DEPTH(PROG_DEPTH)) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (tbl_rd_addr),
    .wr       (tbl_wr),
    .rd_data  (rd_entry),
    .clearing (clearing)
  );

  bmt_ctrl #(.PROG_DEPTH(PROG_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .position    (position),
    .clearing    (clearing),
    .stk_top     (stk_top),
    .stk_empty   (stk_empty),
    .stk_full    (stk_full),
    .rd_entry    (rd_entry),
    .busy        (busy),
    .stk_ctl     (stk_ctl),
    .tbl_wr      (tbl_wr),
    .tbl_rd_addr (tbl_rd_addr),
    .done        (done),
    .status      (status),
    .kind        (kind),
    .partner     (partner)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bmt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int POS_MAX = (1 << POS_W) - 1;

  typedef struct {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
  } bracket_word_t;

  typedef struct {
    status_t          status;
    kind_t            kind;
    logic [POS_W-1:0] partner;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       cmd = '0;
  logic [POS_W-1:0] position = '0;
  logic             busy;
  logic             done;
  logic [2:0]       status;
  logic [1:0]       kind;
  logic [POS_W-1:0] partner;

  bracket_word_t pending_cmds[$];
  answer_t       expected_answers[$];
  int            idle_pct = 0;
  int            err_cnt = 0;

  // bracket state as the block should hold it
  logic [POS_W-1:0] open_pos[STACK_DEPTH_DEF];
  int               open_cnt;
  kind_t            jump_kind[PROG_DEPTH_DEF];
  logic [POS_W-1:0] jump_partner[PROG_DEPTH_DEF];

  // stack shadow used only to shape the stimulus
  logic [POS_W-1:0] gen_stack[$];
  logic [POS_W-1:0] recent_pos[$];
  int               cursor;

  answer_t       drv_answer;
  bracket_word_t drv_word;
  answer_t       mon_want;

  bracket_match_table u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .position (position),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .kind     (kind),
    .partner  (partner)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void track_bracket_cmd(input logic [1:0] op, input logic [POS_W-1:0] pos,
                                            output answer_t ans);
    logic [POS_W-1:0] left;
    ans.status  = STAT_OK;
    ans.kind    = KIND_UNKNOWN;
    ans.partner = '0;
    if (op == CMD_UNUSED) begin
      // ignored, answers all zero
    end else if (int'(pos) >= PROG_DEPTH_DEF) begin
      ans.status = STAT_RANGE;
    end else if (op == CMD_OPEN) begin
      if (open_cnt >= STACK_DEPTH_DEF) begin
        ans.status = STAT_FULL;
      end else begin
        open_pos[open_cnt] = pos;
        open_cnt++;
      end
    end else if (op == CMD_CLOSE) begin
      if (open_cnt == 0) begin
        ans.status = STAT_EMPTY;
      end else begin
        left = open_pos[open_cnt-1];
        if (left >= pos) begin
          ans.status = STAT_ORDER;
        end else begin
          open_cnt--;
          jump_kind[left]    = KIND_OPEN;
          jump_partner[left] = pos;
          jump_kind[pos]     = KIND_CLOSE;
          jump_partner[pos]  = left;
        end
      end
    end else begin
      if (jump_kind[pos] != KIND_UNKNOWN) begin
        ans.kind    = jump_kind[pos];
        ans.partner = jump_partner[pos];
      end
    end
  endfunction

  // driver: start stays up until the word is taken
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      cmd      <= '0;
      position <= '0;
    end else begin
      if (start && !busy) begin
        track_bracket_cmd(cmd, position, drv_answer);
        expected_answers.push_back(drv_answer);
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          drv_word = pending_cmds.pop_front();
          start    <= 1'b1;
          cmd      <= drv_word.op;
          position <= drv_word.pos;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: one result word per done strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $error("result word with nothing expected: status %0d kind %0d partner %0d",
               status, kind, partner);
        err_cnt++;
      end else begin
        mon_want = expected_answers.pop_front();
        if (status !== mon_want.status) begin
          $error("status: expected %0d, got %0d", mon_want.status, status);
          err_cnt++;
        end
        if (kind !== mon_want.kind) begin
          $error("kind: expected %0d, got %0d", mon_want.kind, kind);
          err_cnt++;
        end
        if (partner !== mon_want.partner) begin
          $error("partner: expected %0d, got %0d", mon_want.partner, partner);
          err_cnt++;
        end
      end
    end
  end

  task automatic queue_word(input logic [1:0] op, input logic [POS_W-1:0] pos);
    bracket_word_t w;
    w.op  = op;
    w.pos = pos;
    if (op == CMD_OPEN && gen_stack.size() < STACK_DEPTH_DEF) begin
      gen_stack.push_back(pos);
    end else if (op == CMD_CLOSE && gen_stack.size() > 0 && gen_stack[$] < pos) begin
      void'(gen_stack.pop_back());
    end
    if (op == CMD_OPEN || op == CMD_CLOSE) begin
      recent_pos.push_back(pos);
      if (recent_pos.size() > 64) void'(recent_pos.pop_front());
    end
    pending_cmds.push_back(w);
  endtask

  task automatic queue_random_word();
    int               r;
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // noise: anything, including broken closes
      op  = 2'($urandom_range(0, 3));
      pos = POS_W'($urandom_range(0, POS_MAX));
      if (op == CMD_OPEN && pos == POS_MAX) pos = POS_W'(POS_MAX - 1);
    end else if (r < 24) begin
      op = CMD_LOOKUP;
      if (recent_pos.size() > 0 && $urandom_range(0, 3) != 0)
        pos = recent_pos[$urandom_range(0, recent_pos.size() - 1)];
      else
        pos = POS_W'($urandom_range(0, POS_MAX));
    end else if (gen_stack.size() == 0 ||
                 (gen_stack.size() < 48 && cursor + gen_stack.size() < POS_MAX - 200 &&
                  $urandom_range(0, 99) < 55)) begin
      op = CMD_OPEN;
      if (cursor > POS_MAX - 1) cursor = $urandom_range(0, 1500);
      pos    = POS_W'(cursor);
      cursor = cursor + $urandom_range(1, 4);
    end else begin
      op = CMD_CLOSE;
      if (cursor > POS_MAX) cursor = POS_MAX;
      if (gen_stack[$] >= cursor) cursor = gen_stack[$] + 1;
      pos    = POS_W'(cursor);
      cursor = cursor + $urandom_range(1, 4);
      if (gen_stack.size() == 1 && cursor > POS_MAX - 300) cursor = $urandom_range(0, 1500);
    end
    queue_word(op, pos);
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || start || expected_answers.size() > 0) @(posedge clk);
  endtask

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    open_cnt = 0;
    cursor   = 0;
    for (int i = 0; i < PROG_DEPTH_DEF; i++) begin
      jump_kind[i]    = KIND_UNKNOWN;
      jump_partner[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: edges of the position range, errors, nesting, reuse
    @(negedge clk);
    idle_pct = 0;
    queue_word(CMD_LOOKUP, 0);
    queue_word(CMD_LOOKUP, POS_W'(POS_MAX));
    queue_word(CMD_CLOSE, 10);          // nothing open
    queue_word(CMD_UNUSED, POS_W'(POS_MAX));
    queue_word(CMD_OPEN, 0);
    queue_word(CMD_CLOSE, POS_W'(POS_MAX));
    queue_word(CMD_LOOKUP, 0);
    queue_word(CMD_LOOKUP, POS_W'(POS_MAX));
    queue_word(CMD_OPEN, 100);
    queue_word(CMD_CLOSE, 100);         // open not before close
    queue_word(CMD_CLOSE, 50);
    queue_word(CMD_CLOSE, 101);
    queue_word(CMD_OPEN, 200);
    queue_word(CMD_OPEN, 201);
    queue_word(CMD_CLOSE, 202);
    queue_word(CMD_CLOSE, 203);
    queue_word(CMD_LOOKUP, 200);
    queue_word(CMD_LOOKUP, 201);
    queue_word(CMD_LOOKUP, 202);
    queue_word(CMD_LOOKUP, 203);
    queue_word(CMD_OPEN, 0);            // reuse of a matched position
    queue_word(CMD_CLOSE, 5);
    queue_word(CMD_LOOKUP, 0);
    queue_word(CMD_LOOKUP, POS_W'(POS_MAX));
    queue_word(CMD_LOOKUP, 101);
    drain();

    // fill the stack past full, then unwind it completely
    @(negedge clk);
    while (gen_stack.size() < STACK_DEPTH_DEF)
      queue_word(CMD_OPEN, POS_W'(1000 + gen_stack.size()));
    repeat (3) queue_word(CMD_OPEN, 1900);
    queue_word(CMD_LOOKUP, 1000);
    for (int i = 0; gen_stack.size() > 0; i++) queue_word(CMD_CLOSE, POS_W'(2000 + i));
    queue_word(CMD_CLOSE, 3000);
    queue_word(CMD_LOOKUP, 1000);
    queue_word(CMD_LOOKUP, 2000);
    drain();

    @(negedge clk);
    idle_pct = 60;
    repeat (60) queue_random_word();
    drain();

    @(negedge clk);
    idle_pct = 18;
    repeat (60) queue_random_word();
    drain();

    @(negedge clk);
    idle_pct = 0;
    repeat (40) queue_random_word();
    drain();

    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
